[hdl/pssm_pkg.sv]
// ----------------------------------------------------------------------------
// pssm_pkg
// Types, constants and step table for the pendulum swing motor sequencer.
// ----------------------------------------------------------------------------
package pssm_pkg;

  localparam int POSITION_WIDTH_DEF = 16;
  localparam int WAIT_WIDTH_DEF     = 20;

  localparam int DELAY_W  = 9;
  localparam int LIMIT_W  = 15;
  localparam int TICKS_W  = 20;
  localparam int STEP_W   = 5;
  localparam int POS_OUT_W = 16;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_FIRE_DELAY_START = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRE_DELAY_RING  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OVERTRAVEL_LIMIT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RING_HIGH        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RING_LOW         = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_TICKS     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_ARC_DELAY_TICKS  = 3'd6;

  localparam logic [DELAY_W-1:0] FIRE_DELAY_START_RST = 9'd21;
  localparam logic [DELAY_W-1:0] FIRE_DELAY_RING_RST  = 9'd119;
  localparam logic [LIMIT_W-1:0] OVERTRAVEL_LIMIT_RST = 15'd2000;
  localparam logic [LIMIT_W-1:0] RING_HIGH_RST        = 15'd800;
  localparam logic [LIMIT_W-1:0] RING_LOW_RST         = 15'd400;
  localparam logic [TICKS_W-1:0] SETTLE_TICKS_RST     = 20'd117188;
  localparam logic [TICKS_W-1:0] ARC_DELAY_TICKS_RST  = 20'd58594;

  localparam logic [DELAY_W-1:0] DELAY_MAX      = 9'd256;
  localparam logic [STEP_W-1:0]  RING_FIRST     = 5'd13;
  localparam logic [STEP_W-1:0]  RING_LAST      = 5'd16;
  localparam logic [STEP_W-1:0]  STEP_FIRST     = 5'd0;
  localparam int                 UNDERSWING_LIM = 200;

  typedef enum logic [1:0] {
    PH_SETTLE = 2'd0,
    PH_ARC    = 2'd1,
    PH_RUN    = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    DRV_STOP = 2'd0,
    DRV_FWD  = 2'd1,
    DRV_REV  = 2'd2
  } drv_t;

  typedef struct packed {
    drv_t               kind;
    logic               hold_ge;
    logic signed [15:0] lim;
  } seq_entry_t;

  typedef struct packed {
    logic               triac_forward;
    logic               triac_reverse;
    logic               relay_on;
    logic               trip;
    logic signed [POS_OUT_W-1:0] position;
    logic [STEP_W-1:0]  step_index;
  } result_t;

  function automatic seq_entry_t step_entry(input logic [STEP_W-1:0]  s,
                                            input logic [LIMIT_W-1:0] ring_high,
                                            input logic [LIMIT_W-1:0] ring_low);
    seq_entry_t e;
    logic signed [15:0] hi;
    logic signed [15:0] lo;
    hi = signed'({1'b0, ring_high});
    lo = signed'({1'b0, ring_low});
    case (s)
      5'd0:  e = '{DRV_FWD,  1'b0,  16'sd200};
      5'd1:  e = '{DRV_STOP, 1'b1,  16'sd0};
      5'd2:  e = '{DRV_REV,  1'b1, -16'sd200};
      5'd3:  e = '{DRV_STOP, 1'b0,  16'sd0};
      5'd4:  e = '{DRV_FWD,  1'b0,  16'sd400};
      5'd5:  e = '{DRV_STOP, 1'b1,  16'sd0};
      5'd6:  e = '{DRV_REV,  1'b1, -16'sd400};
      5'd7:  e = '{DRV_STOP, 1'b0,  16'sd0};
      5'd8:  e = '{DRV_FWD,  1'b0,  16'sd800};
      5'd9:  e = '{DRV_STOP, 1'b1,  16'sd0};
      5'd10: e = '{DRV_REV,  1'b1, -16'sd800};
      5'd11: e = '{DRV_STOP, 1'b0,  16'sd0};
      5'd12: e = '{DRV_FWD,  1'b0,  16'sd1200};
      5'd13: e = '{DRV_STOP, 1'b1,  lo};
      5'd14: e = '{DRV_REV,  1'b1,  -hi};
      5'd15: e = '{DRV_STOP, 1'b0,  -lo};
      default: e = '{DRV_FWD, 1'b0, hi};
    endcase
    return e;
  endfunction

  function automatic logic [DELAY_W-1:0] clamp_delay(input logic [DELAY_W-1:0] d);
    return ((d == '0) || (d > DELAY_MAX)) ? DELAY_MAX : d;
  endfunction

endpackage

[hdl/pendulum_swing_motor_sequencer_top.sv]
// ----------------------------------------------------------------------------
// pendulum_swing_motor_sequencer_top
// Encoder position counter, settle/arc/run phase control, swing step
// sequencer and triac firing countdown, one tick item in, one result out.
// ----------------------------------------------------------------------------
// The two-entry output buffer registers each accepted tick's result in the
// output register, or in the skid entry while a result waits under out_stall.
// Throughput: 1 tick item per cycle while in_stall (a full skid entry) is low.
// Reset: synchronous rst_n clears all sequencer state, loads register defaults and
// empties the output buffer.
module pendulum_swing_motor_sequencer_top
  import pssm_pkg::*;
#(
  parameter int POSITION_WIDTH = POSITION_WIDTH_DEF,
  parameter int WAIT_WIDTH     = WAIT_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [TICKS_W-1:0]          cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_zero_cross,
  input  logic                        in_encoder_step,
  input  logic                        in_encoder_dir,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_triac_forward,
  output logic                        out_triac_reverse,
  output logic                        out_relay_on,
  output logic                        out_trip,
  output logic signed [POS_OUT_W-1:0] out_position,
  output logic [STEP_W-1:0]           out_step_index
);

  localparam int CW = ((POSITION_WIDTH > 16) ? POSITION_WIDTH : 16) + 1;
  localparam int WC = (WAIT_WIDTH > TICKS_W) ? WAIT_WIDTH : TICKS_W;

  // configuration
  logic [DELAY_W-1:0] fire_delay_start_r, fire_delay_ring_r;
  logic [LIMIT_W-1:0] overtravel_limit_r, ring_high_r, ring_low_r;
  logic [TICKS_W-1:0] settle_ticks_r, arc_delay_ticks_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fire_delay_start_r <= FIRE_DELAY_START_RST;
      fire_delay_ring_r  <= FIRE_DELAY_RING_RST;
      overtravel_limit_r <= OVERTRAVEL_LIMIT_RST;
      ring_high_r        <= RING_HIGH_RST;
      ring_low_r         <= RING_LOW_RST;
      settle_ticks_r     <= SETTLE_TICKS_RST;
      arc_delay_ticks_r  <= ARC_DELAY_TICKS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FIRE_DELAY_START: fire_delay_start_r <= cfg_data[DELAY_W-1:0];
        CFG_FIRE_DELAY_RING:  fire_delay_ring_r  <= cfg_data[DELAY_W-1:0];
        CFG_OVERTRAVEL_LIMIT: overtravel_limit_r <= cfg_data[LIMIT_W-1:0];
        CFG_RING_HIGH:        ring_high_r        <= cfg_data[LIMIT_W-1:0];
        CFG_RING_LOW:         ring_low_r         <= cfg_data[LIMIT_W-1:0];
        CFG_SETTLE_TICKS:     settle_ticks_r     <= cfg_data;
        CFG_ARC_DELAY_TICKS:  arc_delay_ticks_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer state
  logic [POSITION_WIDTH-1:0] pos_r, pos_nxt;
  phase_t                    phase_r, phase_nxt;
  logic [STEP_W-1:0]         step_r, step_nxt;
  logic [WAIT_WIDTH-1:0]     wait_r, wait_nxt;
  logic [DELAY_W-1:0]        fire_cnt_r, fire_cnt_nxt;
  logic                      armed_r, armed_nxt;
  logic                      gate_fwd_r, gate_fwd_nxt;
  logic                      gate_rev_r, gate_rev_nxt;
  logic                      relay_r, relay_nxt;

  logic                      in_acc;
  logic                      tripped;
  drv_t                      drive;
  seq_entry_t                ent_cur, ent_new;
  logic                      hold;
  logic signed [CW-1:0]      p_ext, lim_ext, ot_lim, under_lim;
  logic [WC-1:0]             wait_ext, settle_ext, arc_ext;
  logic [DELAY_W-1:0]        delay_sel;
  logic                      starter;
  logic [POSITION_WIDTH+POS_OUT_W-1:0] pos_wide;
  result_t                   res_nxt;

  assign ot_lim    = signed'({{(CW-LIMIT_W){1'b0}}, overtravel_limit_r});
  assign under_lim = -signed'(CW'(UNDERSWING_LIM));
  assign settle_ext = WC'(settle_ticks_r);
  assign arc_ext    = WC'(arc_delay_ticks_r);

  always_comb begin
    pos_nxt      = pos_r;
    phase_nxt    = phase_r;
    step_nxt     = step_r;
    wait_nxt     = wait_r;
    fire_cnt_nxt = fire_cnt_r;
    armed_nxt    = armed_r;
    gate_fwd_nxt = gate_fwd_r;
    gate_rev_nxt = gate_rev_r;
    relay_nxt    = relay_r;
    tripped      = 1'b0;
    drive        = DRV_STOP;
    hold         = 1'b0;
    ent_cur      = step_entry(STEP_FIRST, ring_high_r, ring_low_r);
    ent_new      = ent_cur;
    lim_ext      = '0;
    wait_ext     = '0;
    delay_sel    = '0;
    starter      = 1'b1;

    if (in_encoder_step) begin
      pos_nxt = in_encoder_dir ? pos_r + 1'b1 : pos_r - 1'b1;
    end
    p_ext = signed'({{(CW-POSITION_WIDTH){pos_nxt[POSITION_WIDTH-1]}}, pos_nxt});

    case (phase_r)
      PH_RUN: begin
        if (step_r > RING_LAST) begin
          step_nxt = RING_FIRST;
        end
        if ((p_ext >= ot_lim) || (p_ext <= -ot_lim) ||
            ((step_nxt == STEP_FIRST) && (p_ext <= under_lim))) begin
          phase_nxt    = PH_SETTLE;
          wait_nxt     = '0;
          step_nxt     = STEP_FIRST;
          pos_nxt      = '0;
          armed_nxt    = 1'b0;
          fire_cnt_nxt = '0;
          gate_fwd_nxt = 1'b0;
          gate_rev_nxt = 1'b0;
          relay_nxt    = 1'b0;
          tripped      = 1'b1;
        end else begin
          ent_cur = step_entry(step_nxt, ring_high_r, ring_low_r);
          lim_ext = signed'({{(CW-16){ent_cur.lim[15]}}, ent_cur.lim});
          hold    = ent_cur.hold_ge ? (p_ext >= lim_ext) : (p_ext <= lim_ext);
          if (!hold) begin
            step_nxt = (step_nxt == RING_LAST) ? RING_FIRST : step_nxt + 1'b1;
          end
          ent_new = step_entry(step_nxt, ring_high_r, ring_low_r);
          drive   = ent_new.kind;
        end
      end
      PH_ARC: begin
        relay_nxt = 1'b1;
        wait_ext  = WC'(wait_r);
        if (wait_ext >= arc_ext) begin
          phase_nxt = PH_RUN;
          step_nxt  = STEP_FIRST;
          wait_nxt  = '0;
        end else if (!(&wait_r)) begin
          wait_nxt = wait_r + 1'b1;
        end
      end
      default: begin
        phase_nxt = PH_SETTLE;
        relay_nxt = 1'b0;
        if (in_encoder_step) begin
          wait_nxt = '0;
        end else if (!(&wait_r)) begin
          wait_nxt = wait_r + 1'b1;
        end
        wait_ext = WC'(wait_nxt);
        if ((wait_ext >= settle_ext) && (wait_nxt != '0)) begin
          pos_nxt   = '0;
          relay_nxt = 1'b1;
          phase_nxt = PH_ARC;
          wait_nxt  = '0;
        end
      end
    endcase

    case (drive)
      DRV_FWD: gate_rev_nxt = 1'b0;
      DRV_REV: gate_fwd_nxt = 1'b0;
      default: begin
        gate_fwd_nxt = 1'b0;
        gate_rev_nxt = 1'b0;
      end
    endcase

    starter   = !((phase_nxt == PH_RUN) && (step_nxt >= RING_FIRST));
    delay_sel = starter ? fire_delay_start_r : fire_delay_ring_r;
    if (in_zero_cross) begin
      gate_fwd_nxt = 1'b0;
      gate_rev_nxt = 1'b0;
      fire_cnt_nxt = clamp_delay(delay_sel);
      armed_nxt    = 1'b1;
    end else if (armed_r) begin
      if (fire_cnt_nxt != '0) begin
        fire_cnt_nxt = fire_cnt_nxt - 1'b1;
      end
      if (fire_cnt_nxt == '0) begin
        armed_nxt = 1'b0;
        if (drive == DRV_FWD) begin
          gate_fwd_nxt = 1'b1;
        end else if (drive == DRV_REV) begin
          gate_rev_nxt = 1'b1;
        end
      end
    end
  end

  assign pos_wide = {{POS_OUT_W{1'b0}}, pos_nxt};

  always_comb begin
    res_nxt.triac_forward = gate_fwd_nxt;
    res_nxt.triac_reverse = gate_rev_nxt;
    res_nxt.relay_on      = relay_nxt;
    res_nxt.trip          = tripped;
    res_nxt.position      = signed'(pos_wide[POS_OUT_W-1:0]);
    res_nxt.step_index    = (phase_nxt == PH_RUN) ? step_nxt : STEP_FIRST;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      phase_r    <= PH_SETTLE;
      step_r     <= '0;
      wait_r     <= '0;
      fire_cnt_r <= '0;
      armed_r    <= 1'b0;
      gate_fwd_r <= 1'b0;
      gate_rev_r <= 1'b0;
      relay_r    <= 1'b0;
    end else if (in_acc) begin
      pos_r      <= pos_nxt;
      phase_r    <= phase_nxt;
      step_r     <= step_nxt;
      wait_r     <= wait_nxt;
      fire_cnt_r <= fire_cnt_nxt;
      armed_r    <= armed_nxt;
      gate_fwd_r <= gate_fwd_nxt;
      gate_rev_r <= gate_rev_nxt;
      relay_r    <= relay_nxt;
    end
  end

  // output register plus skid entry
  logic    out_vld_r, skid_vld_r;
  result_t out_res_r, skid_res_r;
  logic    out_take;

  assign in_stall = skid_vld_r;
  assign in_acc   = in_valid && !skid_vld_r;
  assign out_take = out_vld_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (out_take) begin
      if (skid_vld_r) begin
        skid_vld_r <= 1'b0;
      end else begin
        out_vld_r <= in_acc;
      end
    end else if (!out_vld_r) begin
      out_vld_r <= in_acc;
    end else if (in_acc) begin
      skid_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take && skid_vld_r) begin
      out_res_r <= skid_res_r;
    end else if (in_acc && (out_take || !out_vld_r)) begin
      out_res_r <= res_nxt;
    end else if (in_acc) begin
      skid_res_r <= res_nxt;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_triac_forward = out_res_r.triac_forward;
  assign out_triac_reverse = out_res_r.triac_reverse;
  assign out_relay_on      = out_res_r.relay_on;
  assign out_trip          = out_res_r.trip;
  assign out_position      = out_res_r.position;
  assign out_step_index    = out_res_r.step_index;

endmodule

[test/tb_pendulum_swing_motor_sequencer_top.sv]
// ----------------------------------------------------------------------------
// tb_pendulum_swing_motor_sequencer_top
// Self-checking bench for the swing motor sequencer. A short table of ticks
// and register writes comes first. Random ticks follow in mixes: noise, a
// steered swing that walks the first starter steps, and trip runs for
// overtravel and starter underswing. Results are checked against a tick-level
// model or a typed row's fixed result. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_pendulum_swing_motor_sequencer_top;
  import pssm_pkg::*;

  localparam int CYCLE_LIMIT = 600000;

  typedef enum {ROW_TICK, ROW_REG} row_kind_t;
  typedef enum {MIX_NOISE, MIX_SWING, MIX_TRIP} mix_t;

  typedef struct {
    row_kind_t            kind;
    logic                 zc;
    logic                 st;
    logic                 dir;
    logic [CFG_IDX_W-1:0] idx;
    logic [TICKS_W-1:0]   val;
    logic                 typed;
    result_t              want;
  } plan_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [TICKS_W-1:0]   cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_zero_cross = 1'b0;
  logic                 in_encoder_step = 1'b0;
  logic                 in_encoder_dir = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_triac_forward;
  logic                 out_triac_reverse;
  logic                 out_relay_on;
  logic                 out_trip;
  logic signed [POS_OUT_W-1:0] out_position;
  logic [STEP_W-1:0]    out_step_index;

  pendulum_swing_motor_sequencer_top uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_zero_cross    (in_zero_cross),
    .in_encoder_step  (in_encoder_step),
    .in_encoder_dir   (in_encoder_dir),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_triac_forward(out_triac_forward),
    .out_triac_reverse(out_triac_reverse),
    .out_relay_on     (out_relay_on),
    .out_trip         (out_trip),
    .out_position     (out_position),
    .out_step_index   (out_step_index)
  );

  // sequencer model state
  logic [15:0]        pos_q;
  phase_t             phase_q;
  logic [STEP_W-1:0]  step_q;
  logic [19:0]        wait_q;
  logic [DELAY_W-1:0] fire_q;
  logic               armed_q, gf_q, gr_q, relay_q;

  logic [DELAY_W-1:0] dly_start, dly_ring;
  logic [LIMIT_W-1:0] ot_lim, ring_hi, ring_lo;
  logic [TICKS_W-1:0] settle_n, arc_n;

  result_t     pending_outputs[$];
  plan_row_t   plan[$];
  result_t     want;
  int          failures = 0;
  int          cycles = 0;
  int          ring_ticks = 0;
  bit          bubbles_on = 1'b1;

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[pendulum_swing_motor_sequencer_top] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= bubbles_on && ($urandom_range(99) < 20);
  end

  task automatic clear_state();
    phase_q = PH_SETTLE;
    wait_q  = '0;
    step_q  = STEP_FIRST;
    pos_q   = '0;
    armed_q = 1'b0;
    fire_q  = '0;
    gf_q    = 1'b0;
    gr_q    = 1'b0;
    relay_q = 1'b0;
  endtask

  task automatic reset_model();
    dly_start = FIRE_DELAY_START_RST;
    dly_ring  = FIRE_DELAY_RING_RST;
    ot_lim    = OVERTRAVEL_LIMIT_RST;
    ring_hi   = RING_HIGH_RST;
    ring_lo   = RING_LOW_RST;
    settle_n  = SETTLE_TICKS_RST;
    arc_n     = ARC_DELAY_TICKS_RST;
    clear_state();
  endtask

  function automatic logic [DELAY_W-1:0] eff_delay(input logic [DELAY_W-1:0] d);
    return (d == '0 || d > DELAY_MAX) ? DELAY_MAX : d;
  endfunction

  function automatic drv_t step_drive(input logic [STEP_W-1:0] s);
    if (s >= RING_FIRST)
      return (s == RING_FIRST + 5'd1) ? DRV_REV : (s == RING_LAST) ? DRV_FWD : DRV_STOP;
    case (s[1:0])
      2'd0: return DRV_FWD;
      2'd2: return DRV_REV;
      default: return DRV_STOP;
    endcase
  endfunction

  // true while the step keeps its place for position p
  function automatic logic step_holds(input logic [STEP_W-1:0] s, input int p);
    int amp;
    amp = (s < 5'd4) ? 200 : (s < 5'd8) ? 400 : (s < 5'd12) ? 800 : 1200;
    if (s < RING_FIRST) begin
      case (s[1:0])
        2'd0: return p <= amp;
        2'd1: return p >= 0;
        2'd2: return p >= -amp;
        default: return p <= 0;
      endcase
    end
    case (s - RING_FIRST)
      5'd0: return p >= int'(ring_lo);
      5'd1: return p >= -int'(ring_hi);
      5'd2: return p <= -int'(ring_lo);
      default: return p <= int'(ring_hi);
    endcase
  endfunction

  function automatic logic wants_up(input logic [STEP_W-1:0] s);
    if (s >= RING_FIRST) return s >= RING_FIRST + 5'd2;
    return s[1:0] == 2'd0 || s[1:0] == 2'd3;
  endfunction

  task automatic advance_sequencer(input logic zc, st, dir, output result_t r);
    int   p;
    drv_t drv;
    logic tripped;
    logic starter;
    drv = DRV_STOP;
    tripped = 1'b0;
    if (st) pos_q = dir ? pos_q + 16'd1 : pos_q - 16'd1;
    if (phase_q == PH_RUN) begin
      if (step_q > RING_LAST) step_q = RING_FIRST;
      p = int'($signed(pos_q));
      if (p >= int'(ot_lim) || p <= -int'(ot_lim) ||
          (step_q == STEP_FIRST && p <= -UNDERSWING_LIM)) begin
        clear_state();
        tripped = 1'b1;
      end else begin
        if (!step_holds(step_q, p))
          step_q = (step_q == RING_LAST) ? RING_FIRST : step_q + 5'd1;
        drv = step_drive(step_q);
      end
    end else if (phase_q == PH_ARC) begin
      relay_q = 1'b1;
      if (wait_q >= arc_n) begin
        phase_q = PH_RUN;
        step_q  = STEP_FIRST;
        wait_q  = '0;
      end else if (wait_q != '1) begin
        wait_q = wait_q + 20'd1;
      end
    end else begin
      phase_q = PH_SETTLE;
      relay_q = 1'b0;
      if (st) wait_q = '0;
      else if (wait_q != '1) wait_q = wait_q + 20'd1;
      if (wait_q >= settle_n && wait_q != '0) begin
        pos_q   = '0;
        relay_q = 1'b1;
        phase_q = PH_ARC;
        wait_q  = '0;
      end
    end

    case (drv)
      DRV_STOP: begin
        gf_q = 1'b0;
        gr_q = 1'b0;
      end
      DRV_FWD: gr_q = 1'b0;
      default: gf_q = 1'b0;
    endcase

    if (zc) begin
      gf_q = 1'b0;
      gr_q = 1'b0;
      starter = !(phase_q == PH_RUN && step_q >= RING_FIRST);
      fire_q  = eff_delay(starter ? dly_start : dly_ring);
      armed_q = 1'b1;
    end else if (armed_q) begin
      if (fire_q != '0) fire_q = fire_q - 9'd1;
      if (fire_q == '0) begin
        armed_q = 1'b0;
        if (drv == DRV_FWD) gf_q = 1'b1;
        else if (drv == DRV_REV) gr_q = 1'b1;
      end
    end

    r.triac_forward = gf_q;
    r.triac_reverse = gr_q;
    r.relay_on      = relay_q;
    r.trip          = tripped;
    r.position      = $signed(pos_q);
    r.step_index    = (phase_q == PH_RUN) ? step_q : STEP_FIRST;
  endtask

  function automatic result_t result_of(input logic f, rv, rl, tr,
                                        input logic signed [15:0] pos,
                                        input logic [STEP_W-1:0] s);
    result_t r;
    r.triac_forward = f;
    r.triac_reverse = rv;
    r.relay_on      = rl;
    r.trip          = tr;
    r.position      = pos;
    r.step_index    = s;
    return r;
  endfunction

  function automatic plan_row_t tick_row(input logic zc, st, dir, input logic typed = 1'b0,
                                         input result_t w = '0);
    plan_row_t r;
    r.kind  = ROW_TICK;
    r.zc    = zc;
    r.st    = st;
    r.dir   = dir;
    r.idx   = '0;
    r.val   = '0;
    r.typed = typed;
    r.want  = w;
    return r;
  endfunction

  function automatic plan_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [TICKS_W-1:0] val);
    plan_row_t r;
    r       = tick_row(1'b0, 1'b0, 1'b0);
    r.kind  = ROW_REG;
    r.idx   = idx;
    r.val   = val;
    return r;
  endfunction

  task automatic check_field(input string name, input int w, input int got);
    if (w != got) begin
      failures++;
      if (failures <= 200)
        $display("%0t %s mismatch: expected %0d actual %0d", $time, name, w, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_outputs.size() == 0) begin
        failures++;
        if (failures <= 200)
          $display("%0t result with none expected: expected none actual pos %0d",
                   $time, out_position);
      end else begin
        want = pending_outputs.pop_front();
        check_field("triac_forward", int'(want.triac_forward), int'(out_triac_forward));
        check_field("triac_reverse", int'(want.triac_reverse), int'(out_triac_reverse));
        check_field("relay_on", int'(want.relay_on), int'(out_relay_on));
        check_field("trip", int'(want.trip), int'(out_trip));
        check_field("position", int'(want.position), int'(out_position));
        check_field("step_index", int'(want.step_index), int'(out_step_index));
      end
    end
  end

  task automatic send_tick(input logic zc, st, dir, input logic typed, input result_t w);
    result_t r;
    cfg_we <= 1'b0;
    while (bubbles_on && $urandom_range(99) < 20) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_zero_cross   <= zc;
    in_encoder_step <= st;
    in_encoder_dir  <= dir;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    advance_sequencer(zc, st, dir, r);
    pending_outputs.push_back(typed ? w : r);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TICKS_W-1:0] val);
    in_valid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      CFG_FIRE_DELAY_START: dly_start = val[DELAY_W-1:0];
      CFG_FIRE_DELAY_RING:  dly_ring  = val[DELAY_W-1:0];
      CFG_OVERTRAVEL_LIMIT: ot_lim    = val[LIMIT_W-1:0];
      CFG_RING_HIGH:        ring_hi   = val[LIMIT_W-1:0];
      CFG_RING_LOW:         ring_lo   = val[LIMIT_W-1:0];
      CFG_SETTLE_TICKS:     settle_n  = val;
      CFG_ARC_DELAY_TICKS:  arc_n     = val;
      default: ;
    endcase
  endtask

  function automatic logic [TICKS_W-1:0] pick_edge(input int bits);
    logic [TICKS_W-1:0] all;
    all = (20'd1 << bits) - 20'd1;
    case ($urandom_range(3))
      0: return '0;
      1: return all;
      2: return 20'd1;
      default: return TICKS_W'($urandom) & all;
    endcase
  endfunction

  task automatic configure(input mix_t mix, input logic invert0);
    logic [TICKS_W-1:0] hi;
    case (mix)
      MIX_SWING: begin
        hi = TICKS_W'($urandom_range(8, 40));
        set_reg(CFG_FIRE_DELAY_START, TICKS_W'($urandom_range(1, 16)));
        set_reg(CFG_FIRE_DELAY_RING, TICKS_W'($urandom_range(1, 16)));
        set_reg(CFG_OVERTRAVEL_LIMIT, TICKS_W'($urandom_range(1250, 32767)));
        set_reg(CFG_RING_HIGH, hi);
        set_reg(CFG_RING_LOW, TICKS_W'($urandom_range(1, int'(hi))));
        set_reg(CFG_SETTLE_TICKS, TICKS_W'($urandom_range(1, 6)));
        set_reg(CFG_ARC_DELAY_TICKS, TICKS_W'($urandom_range(0, 8)));
      end
      MIX_TRIP: begin
        set_reg(CFG_FIRE_DELAY_START, TICKS_W'($urandom_range(0, 20)));
        set_reg(CFG_FIRE_DELAY_RING, TICKS_W'($urandom_range(0, 300)));
        set_reg(CFG_OVERTRAVEL_LIMIT,
                invert0 ? TICKS_W'($urandom_range(250, 2000)) :
                          TICKS_W'($urandom_range(40, 400)));
        set_reg(CFG_RING_HIGH, TICKS_W'($urandom_range(1, 200)));
        set_reg(CFG_RING_LOW, TICKS_W'($urandom_range(1, 200)));
        set_reg(CFG_SETTLE_TICKS, TICKS_W'($urandom_range(1, 6)));
        set_reg(CFG_ARC_DELAY_TICKS, TICKS_W'($urandom_range(0, 40)));
      end
      default: begin
        set_reg(CFG_FIRE_DELAY_START, pick_edge(DELAY_W));
        set_reg(CFG_FIRE_DELAY_RING, pick_edge(DELAY_W));
        set_reg(CFG_OVERTRAVEL_LIMIT, pick_edge(LIMIT_W));
        set_reg(CFG_RING_HIGH, pick_edge(LIMIT_W));
        set_reg(CFG_RING_LOW, pick_edge(LIMIT_W));
        set_reg(CFG_SETTLE_TICKS, pick_edge(TICKS_W));
        set_reg(CFG_ARC_DELAY_TICKS, pick_edge(TICKS_W));
      end
    endcase
  endtask

  // encoder steered toward the next step; invert0 drives step 0 backwards
  task automatic play(input mix_t mix, input logic invert0, input int n, input int ring_goal);
    int   sent;
    logic zc, st, dir, up;
    configure(mix, invert0);
    ring_ticks = 0;
    sent = 0;
    while (sent < n && (ring_goal == 0 || ring_ticks < ring_goal)) begin
      zc  = ($urandom_range(15) == 0);
      st  = 1'($urandom_range(1));
      dir = 1'($urandom_range(1));
      if (mix != MIX_NOISE) begin
        case (phase_q)
          PH_RUN: begin
            st  = ($urandom_range(7) != 0);
            up  = wants_up(step_q) ^ (invert0 && step_q == STEP_FIRST);
            dir = ($urandom_range(9) == 0) ? !up : up;
          end
          PH_ARC: st = ($urandom_range(3) == 0);
          default: st = ($urandom_range(7) == 0);
        endcase
      end
      send_tick(zc, st, dir, 1'b0, '0);
      if (phase_q == PH_RUN && step_q >= RING_FIRST) ring_ticks++;
      sent++;
    end
  endtask

  initial begin
    reset_model();
    plan.push_back(tick_row(1'b0, 1'b1, 1'b1, 1'b1,
                            result_of(1'b0, 1'b0, 1'b0, 1'b0, 16'sd1, STEP_FIRST)));
    plan.push_back(tick_row(1'b0, 1'b1, 1'b0, 1'b1,
                            result_of(1'b0, 1'b0, 1'b0, 1'b0, 16'sd0, STEP_FIRST)));
    plan.push_back(tick_row(1'b0, 1'b1, 1'b0, 1'b1,
                            result_of(1'b0, 1'b0, 1'b0, 1'b0, -16'sd1, STEP_FIRST)));
    plan.push_back(tick_row(1'b1, 1'b0, 1'b1, 1'b1,
                            result_of(1'b0, 1'b0, 1'b0, 1'b0, -16'sd1, STEP_FIRST)));
    plan.push_back(tick_row(1'b0, 1'b0, 1'b0, 1'b1,
                            result_of(1'b0, 1'b0, 1'b0, 1'b0, -16'sd1, STEP_FIRST)));
    // zero settle and arc waits, zero and oversized firing delays
    plan.push_back(reg_row(CFG_SETTLE_TICKS, 20'd0));
    plan.push_back(reg_row(CFG_ARC_DELAY_TICKS, 20'd0));
    plan.push_back(reg_row(CFG_FIRE_DELAY_START, 20'd0));
    plan.push_back(reg_row(CFG_FIRE_DELAY_RING, 20'd300));
    plan.push_back(reg_row(CFG_OVERTRAVEL_LIMIT, 20'd0));
    plan.push_back(tick_row(1'b0, 1'b0, 1'b0));
    plan.push_back(tick_row(1'b0, 1'b0, 1'b1));
    // zero overtravel limit trips on the first run tick
    plan.push_back(tick_row(1'b1, 1'b1, 1'b1, 1'b1,
                            result_of(1'b0, 1'b0, 1'b0, 1'b1, 16'sd0, STEP_FIRST)));
    plan.push_back(reg_row(CFG_OVERTRAVEL_LIMIT, 20'd32767));
    plan.push_back(reg_row(CFG_RING_HIGH, 20'd32767));
    plan.push_back(reg_row(CFG_RING_LOW, 20'd1));
    plan.push_back(reg_row(CFG_SETTLE_TICKS, 20'd1));
    plan.push_back(tick_row(1'b0, 1'b0, 1'b0));
    plan.push_back(tick_row(1'b0, 1'b0, 1'b0));
    plan.push_back(tick_row(1'b1, 1'b1, 1'b1));
    plan.push_back(tick_row(1'b0, 1'b1, 1'b1));
    plan.push_back(tick_row(1'b0, 1'b1, 1'b0));
    plan.push_back(tick_row(1'b0, 1'b0, 1'b0));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) set_reg(plan[i].idx, plan[i].val);
      else send_tick(plan[i].zc, plan[i].st, plan[i].dir, plan[i].typed, plan[i].want);
    end

    play(MIX_NOISE, 1'b0, 150, 0);
    play(MIX_SWING, 1'b0, 600, 0);
    play(MIX_TRIP, 1'b1, 350, 0);
    bubbles_on = 1'b0;
    play(MIX_TRIP, 1'b0, 350, 0);
    play(MIX_NOISE, 1'b0, 100, 0);
    bubbles_on = 1'b1;
    play(MIX_NOISE, 1'b0, 100, 0);

    in_valid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (failures == 0) begin
      $display("[pendulum_swing_motor_sequencer_top] OK");
    end else begin
      $display("[pendulum_swing_motor_sequencer_top] ERROR");
    end
    $finish;
  end

endmodule
